// File: rtl/core/letter_histogram_sorted_macros.svh
// Assertion macros for the letter histogram block.
// Used by letter_histogram_sorted.sv; clocked on clk, disabled while arst_n is low.
`ifndef LETTER_HISTOGRAM_SORTED_MACROS_SVH
`define LETTER_HISTOGRAM_SORTED_MACROS_SVH
`ifndef SYNTHESIS
`define LHS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("letter histogram assertion failed");
`define LHS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("letter histogram assertion failed");
`else
`define LHS_ASSERT_IMPL(lbl, ante, cons)
`define LHS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/lhs_pkg.sv
// Shared types, constants and helpers of the letter histogram block.
// No dependencies.
`timescale 1ns / 1ps
package lhs_pkg;
	localparam int MAX_COUNT   = 65535;
	localparam logic [15:0] SAT_CAP = 16'((MAX_COUNT < 65535) ? MAX_COUNT : 65535);
	localparam int NUM_LETTERS = 26;
	localparam logic [7:0] LETTER_LOW  = 8'd97;
	localparam logic [7:0] LETTER_HIGH = 8'd122;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_word_t;

	typedef struct packed {
		logic [4:0]  letter;
		logic [15:0] occurrences;
		logic [15:0] first_seen;
		logic [4:0]  distinct_letters;
		logic        final_entry;
	} hist_word_t;

	typedef struct packed {
		logic       eot;
		logic       is_zero;
		logic       is_letter;
		logic [4:0] idx;
	} cls_t;

	typedef struct packed {
		logic [4:0]  letter;
		logic [15:0] count;
		logic [15:0] first;
	} slot_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic pop;
	} q_status_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v >= SAT_CAP) ? SAT_CAP : v + 16'd1;
	endfunction
endpackage

// File: rtl/core/lhs_front.sv
// Front end: classifies each incoming text word for the counting back end.
// Depends on lhs_pkg.
`timescale 1ns / 1ps
module lhs_front (
	input  lhs_pkg::text_word_t text,
	output lhs_pkg::cls_t       cls
);
	logic [7:0] ofs;

	assign ofs           = text.text_byte - lhs_pkg::LETTER_LOW;
	assign cls.eot       = text.end_of_text;
	assign cls.is_zero   = (text.text_byte == 8'd0);
	assign cls.is_letter = (text.text_byte >= lhs_pkg::LETTER_LOW) &&
		(text.text_byte <= lhs_pkg::LETTER_HIGH);
	assign cls.idx       = ofs[4:0];
endmodule

// File: rtl/core/lhs_queue.sv
// Small queue of classified words between front and back end.
// Depends on lhs_pkg.
`timescale 1ns / 1ps
module lhs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lhs_pkg::cls_t        push_data,
	input  logic                 pop,
	output lhs_pkg::cls_t        head,
	output lhs_pkg::q_status_t   status
);
	lhs_pkg::cls_t                  mem_q [lhs_pkg::QUEUE_DEPTH];
	logic [lhs_pkg::QUEUE_AW-1:0]   wr_q;
	logic [lhs_pkg::QUEUE_AW-1:0]   rd_q;
	logic [lhs_pkg::QUEUE_CW-1:0]   cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign status.full  = (cnt_q == lhs_pkg::QUEUE_CW'(lhs_pkg::QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign status.pop   = do_pop;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule

// File: rtl/core/lhs_back.sv
// Back end: counts letters, then compacts, exchange-sorts and emits the report.
// Depends on lhs_pkg.
`timescale 1ns / 1ps
module lhs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lhs_pkg::cls_t       item,
	input  logic                item_valid,
	output logic                item_pop,
	output lhs_pkg::hist_word_t hist,
	output logic                hist_valid,
	input  logic                hist_stall
);
	localparam logic [2:0] ST_COUNT   = 3'd0;
	localparam logic [2:0] ST_COMPACT = 3'd1;
	localparam logic [2:0] ST_LOAD    = 3'd2;
	localparam logic [2:0] ST_SCAN    = 3'd3;
	localparam logic [2:0] ST_EMIT    = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;
	localparam logic [4:0] LAST_LETTER = 5'(lhs_pkg::NUM_LETTERS - 1);

	logic [2:0]          state_q;
	logic [15:0]         counts_q [lhs_pkg::NUM_LETTERS];
	logic [15:0]         firsts_q [lhs_pkg::NUM_LETTERS];
	lhs_pkg::slot_t      slots_q  [lhs_pkg::NUM_LETTERS];
	lhs_pkg::slot_t      cur_q;
	lhs_pkg::hist_word_t hist_q;
	logic                hist_valid_q;
	logic [15:0]         pos_q;
	logic                term_q;
	logic [4:0]          scan_q;
	logic [4:0]          i_q;
	logic [4:0]          j_q;
	logic [4:0]          n_q;

	logic [4:0]          cnt_idx;
	logic [15:0]         cnt_rd;
	logic [15:0]         fst_rd;
	logic [15:0]         pos_nx;
	logic [4:0]          slot_idx;
	lhs_pkg::slot_t      slot_rd;
	logic                hit;
	logic [4:0]          n_nx;
	logic [4:0]          i_nx;
	logic                last;
	logic                out_free;
	logic                emit_go;
	logic                clear;

	assign cnt_idx  = (state_q == ST_COUNT) ? item.idx : scan_q;
	assign cnt_rd   = counts_q[cnt_idx];
	assign fst_rd   = firsts_q[cnt_idx];
	assign pos_nx   = lhs_pkg::sat_inc(pos_q);
	assign slot_idx = (state_q == ST_LOAD) ? i_q : j_q;
	assign slot_rd  = slots_q[slot_idx];
	assign hit      = (cnt_rd != 16'd0);
	assign n_nx     = n_q + {4'd0, hit};
	assign i_nx     = i_q + 5'd1;
	assign last     = (i_nx == n_q);
	assign out_free = !hist_valid_q || !hist_stall;
	assign emit_go  = out_free && ((state_q == ST_EMIT) || (state_q == ST_EMPTY));
	assign clear    = emit_go && ((state_q == ST_EMPTY) || last);
	assign item_pop = (state_q == ST_COUNT) && item_valid;
	assign hist       = hist_q;
	assign hist_valid = hist_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_COUNT;
			pos_q        <= '0;
			term_q       <= 1'b0;
			scan_q       <= '0;
			i_q          <= '0;
			j_q          <= '0;
			n_q          <= '0;
			hist_valid_q <= 1'b0;
			for (int k = 0; k < lhs_pkg::NUM_LETTERS; k++) begin
				counts_q[k] <= '0;
				firsts_q[k] <= '0;
			end
		end else begin
			if (emit_go) begin
				hist_valid_q <= 1'b1;
			end else if (!hist_stall) begin
				hist_valid_q <= 1'b0;
			end
			case (state_q)
				ST_COUNT: begin
					if (item_valid) begin
						if (!term_q) begin
							if (item.is_zero) begin
								term_q <= 1'b1;
							end else begin
								pos_q <= pos_nx;
								if (item.is_letter) begin
									counts_q[item.idx] <= lhs_pkg::sat_inc(cnt_rd);
									if (fst_rd == 16'd0) begin
										firsts_q[item.idx] <= pos_nx;
									end
								end
							end
						end
						if (item.eot) begin
							state_q <= ST_COMPACT;
							scan_q  <= '0;
							n_q     <= '0;
						end
					end
				end
				ST_COMPACT: begin
					n_q    <= n_nx;
					scan_q <= scan_q + 5'd1;
					if (scan_q == LAST_LETTER) begin
						i_q     <= '0;
						state_q <= (n_nx == 5'd0) ? ST_EMPTY : ST_LOAD;
					end
				end
				ST_LOAD: begin
					j_q     <= i_nx;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q >= n_q) begin
						state_q <= ST_EMIT;
					end else begin
						j_q <= j_q + 5'd1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						i_q     <= i_nx;
						state_q <= last ? ST_COUNT : ST_LOAD;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_COUNT;
					end
				end
				default: begin
					state_q <= ST_COUNT;
				end
			endcase
			if (clear) begin
				pos_q  <= '0;
				term_q <= 1'b0;
				for (int k = 0; k < lhs_pkg::NUM_LETTERS; k++) begin
					counts_q[k] <= '0;
					firsts_q[k] <= '0;
				end
			end
		end
	end

	// exchange sort: cur_q holds the running winner for slot i
	always_ff @(posedge clk) begin
		if (state_q == ST_COMPACT && hit) begin
			slots_q[n_q] <= '{letter: scan_q, count: cnt_rd, first: fst_rd};
		end
		if (state_q == ST_LOAD) begin
			cur_q <= slot_rd;
		end
		if (state_q == ST_SCAN && j_q < n_q && slot_rd.count > cur_q.count) begin
			slots_q[j_q] <= cur_q;
			cur_q        <= slot_rd;
		end
		if (emit_go) begin
			if (state_q == ST_EMPTY) begin
				hist_q <= '{letter: 5'd0, occurrences: 16'd0, first_seen: 16'd0,
					distinct_letters: 5'd0, final_entry: 1'b1};
			end else begin
				hist_q <= '{letter: cur_q.letter, occurrences: cur_q.count,
					first_seen: cur_q.first, distinct_letters: n_q, final_entry: last};
			end
		end
	end
endmodule

// File: rtl/core/letter_histogram_sorted.sv
// Letter histogram with count-ordered report: one text word per cycle while counting
// and text_stall is low. Words reach the counters through the queue; it holds 4 words.
// Report after the end word: a compaction pass over the 26 letters, then for result i
// of n, a load of slot i and an exchange-sort scan of the later slots before it is emitted.
// Reset (arst_n low) clears counts, first positions and control at once; no clearing pass.
// Depends on lhs_pkg, lhs_front, lhs_queue, lhs_back and letter_histogram_sorted_macros.svh.
`timescale 1ns / 1ps
`include "letter_histogram_sorted_macros.svh"
module letter_histogram_sorted (
	input  logic                clk,
	input  logic                arst_n,
	input  lhs_pkg::text_word_t text,
	input  logic                text_valid,
	output logic                text_stall,
	output lhs_pkg::hist_word_t hist,
	output logic                hist_valid,
	input  logic                hist_stall
);
	lhs_pkg::cls_t      cls;
	lhs_pkg::cls_t      q_head;
	lhs_pkg::q_status_t q_st;
	logic               pop;

	lhs_front u_front (
		.text (text),
		.cls  (cls)
	);

	lhs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (text_valid),
		.push_data (cls),
		.pop       (pop),
		.head      (q_head),
		.status    (q_st)
	);

	lhs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_head),
		.item_valid (!q_st.empty),
		.item_pop   (pop),
		.hist       (hist),
		.hist_valid (hist_valid),
		.hist_stall (hist_stall)
	);

	assign text_stall = q_st.full;

	`LHS_ASSERT_IMPL(a_queue_sane, 1'b1, !(q_st.full && q_st.empty))
	`LHS_ASSERT_IMPL(a_empty_report, hist_valid && hist.distinct_letters == 5'd0,
		hist.final_entry && hist.occurrences == 16'd0)
	`LHS_ASSERT_IMPL(a_real_entry, hist_valid && hist.distinct_letters != 5'd0,
		hist.occurrences != 16'd0 && hist.first_seen != 16'd0)
	`LHS_ASSERT_NEXT(a_full_after_push, q_st.full && !q_st.pop, text_stall || q_st.pop)
endmodule

// File: dv/letter_histogram_sorted_checker.sv
// Checker for letter_histogram_sorted: watches both word channels, predicts the sorted
// letter report of each string and compares every result word field by field.
// Depends on lhs_pkg for the word types and letter constants.
`timescale 1ns / 1ps
module letter_histogram_sorted_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  lhs_pkg::text_word_t text,
	input  logic                text_valid,
	input  logic                text_stall,
	input  lhs_pkg::hist_word_t hist,
	input  logic                hist_valid,
	input  logic                hist_stall,
	output int                  errors,
	output int                  pending
);
	logic [15:0]         letter_count [lhs_pkg::NUM_LETTERS];
	logic [15:0]         first_pos [lhs_pkg::NUM_LETTERS];
	logic [15:0]         text_pos;
	logic                text_closed;
	lhs_pkg::hist_word_t expected_report [$];
	int                  mismatches = 0;

	function automatic logic [15:0] capped_incr(input logic [15:0] v);
		return (v >= lhs_pkg::SAT_CAP) ? lhs_pkg::SAT_CAP : v + 16'd1;
	endfunction

	function automatic void clear_histogram();
		for (int i = 0; i < lhs_pkg::NUM_LETTERS; i++) begin
			letter_count[i] = '0;
			first_pos[i] = '0;
		end
		text_pos = '0;
		text_closed = 1'b0;
	endfunction

	// Count one text word; on the end word build the count-ordered report.
	function automatic void tally_word(input lhs_pkg::text_word_t w);
		lhs_pkg::slot_t      slots [lhs_pkg::NUM_LETTERS];
		lhs_pkg::slot_t      held;
		lhs_pkg::hist_word_t res;
		int                  n;
		int                  k;
		n = 0;
		if (!text_closed) begin
			if (w.text_byte == 8'd0) begin
				text_closed = 1'b1;
			end else begin
				text_pos = capped_incr(text_pos);
				if (w.text_byte >= lhs_pkg::LETTER_LOW &&
					w.text_byte <= lhs_pkg::LETTER_HIGH) begin
					k = int'(w.text_byte - lhs_pkg::LETTER_LOW);
					letter_count[k] = capped_incr(letter_count[k]);
					if (first_pos[k] == 16'd0)
						first_pos[k] = text_pos;
				end
			end
		end
		if (!w.end_of_text)
			return;
		for (int i = 0; i < lhs_pkg::NUM_LETTERS; i++) begin
			if (letter_count[i] != 16'd0) begin
				slots[n].letter = 5'(i);
				slots[n].count = letter_count[i];
				slots[n].first = first_pos[i];
				n++;
			end
		end
		// exchange sort, strictly greater count moves up
		for (int i = 0; i < n; i++) begin
			for (int j = i + 1; j < n; j++) begin
				if (slots[j].count > slots[i].count) begin
					held = slots[i];
					slots[i] = slots[j];
					slots[j] = held;
				end
			end
		end
		if (n == 0) begin
			res = '0;
			res.final_entry = 1'b1;
			expected_report.push_back(res);
		end else begin
			for (int i = 0; i < n; i++) begin
				res.letter = slots[i].letter;
				res.occurrences = slots[i].count;
				res.first_seen = slots[i].first;
				res.distinct_letters = 5'(n);
				res.final_entry = (i == n - 1);
				expected_report.push_back(res);
			end
		end
		clear_histogram();
	endfunction

	function automatic void check_result(input lhs_pkg::hist_word_t got);
		lhs_pkg::hist_word_t want;
		if (expected_report.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: letter=%0d occ=%0d first=%0d distinct=%0d final=%0d",
					got.letter, got.occurrences, got.first_seen, got.distinct_letters,
					got.final_entry);
			return;
		end
		want = expected_report.pop_front();
		if (got.letter !== want.letter || got.occurrences !== want.occurrences ||
			got.first_seen !== want.first_seen ||
			got.distinct_letters !== want.distinct_letters ||
			got.final_entry !== want.final_entry) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: expected letter=%0d occ=%0d first=%0d distinct=%0d final=%0d",
					want.letter, want.occurrences, want.first_seen, want.distinct_letters,
					want.final_entry);
				$display("          actual   letter=%0d occ=%0d first=%0d distinct=%0d final=%0d",
					got.letter, got.occurrences, got.first_seen, got.distinct_letters,
					got.final_entry);
			end
		end
	endfunction

	initial begin
		clear_histogram();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && !text_stall)
				tally_word(text);
			if (hist_valid && !hist_stall)
				check_result(hist);
		end
		errors <= mismatches;
		pending <= expected_report.size();
	end
endmodule

// File: dv/letter_histogram_sorted_tb.sv
// Testbench top for letter_histogram_sorted: drives strings of text words with random gaps
// and result stalls, and gives the verdict from the checker's failure and pending counts.
// Depends on lhs_pkg, letter_histogram_sorted and letter_histogram_sorted_checker.
`timescale 1ns / 1ps
module letter_histogram_sorted_tb;
	logic                clk;
	logic                arst_n = 1'b0;
	lhs_pkg::text_word_t text = '0;
	logic                text_valid = 1'b0;
	logic                text_stall;
	lhs_pkg::hist_word_t hist;
	logic                hist_valid;
	logic                hist_stall = 1'b0;
	int                  errors;
	int                  pending;
	int                  live_words = 0;
	int                  stall_left = 0;
	bit                  tx_quiet = 1'b0;
	bit                  rx_quiet = 1'b0;

	letter_histogram_sorted dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.hist       (hist),
		.hist_valid (hist_valid),
		.hist_stall (hist_stall)
	);

	letter_histogram_sorted_checker hist_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.hist       (hist),
		.hist_valid (hist_valid),
		.hist_stall (hist_stall),
		.errors     (errors),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		if ($urandom_range(0, 399) == 0)
			rx_quiet <= !rx_quiet;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			hist_stall <= 1'b1;
		end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
			hist_stall <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			hist_stall <= 1'b0;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic e);
		int gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text <= '{text_byte: b, end_of_text: e};
		text_valid <= 1'b1;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// One random string; most are well formed letter runs over a random sub-alphabet.
	task automatic send_string();
		int         len, mode, lo, span, zero_at, p;
		logic [7:0] b;
		bit         closed;
		mode = $urandom_range(0, 9);
		len = (mode == 6) ? $urandom_range(40, 120) : $urandom_range(1, 16);
		lo = $urandom_range(0, 25);
		span = $urandom_range(0, 25 - lo);
		if (mode == 6) begin
			lo = 0;
			span = 25;
		end
		zero_at = (mode == 8) ? $urandom_range(0, len - 1) : -1;
		tx_quiet = ($urandom_range(0, 3) == 0);
		closed = 1'b0;
		for (p = 0; p < len; p++) begin
			if (p == zero_at) begin
				b = 8'd0;
			end else if (mode == 7) begin
				b = 8'($urandom_range(0, 255));
			end else if ((mode == 9 && $urandom_range(0, 3) == 0) ||
				$urandom_range(0, 19) == 0) begin
				do
					b = 8'($urandom_range(1, 255));
				while (b >= lhs_pkg::LETTER_LOW && b <= lhs_pkg::LETTER_HIGH);
			end else begin
				b = lhs_pkg::LETTER_LOW + 8'(lo + $urandom_range(0, span));
			end
			if (!closed)
				live_words++;
			if (b == 8'd0)
				closed = 1'b1;
			send_word(b, p == len - 1);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string, then non-letters only
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h60, 1'b0);
		send_word(8'h7B, 1'b1);
		// alphabet ends
		send_word("z", 1'b0);
		send_word("z", 1'b0);
		send_word("a", 1'b1);
		// reorder by count
		send_word("a", 1'b0);
		send_word("b", 1'b0);
		send_word("c", 1'b0);
		send_word("b", 1'b0);
		send_word("c", 1'b0);
		send_word("c", 1'b1);
		// terminator mid string, later letters ignored
		send_word("a", 1'b0);
		send_word("b", 1'b0);
		send_word(8'h00, 1'b0);
		send_word("z", 1'b0);
		send_word("z", 1'b0);
		send_word("z", 1'b1);
		// end marker on the terminator
		send_word("q", 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'h7F, 1'b0);
		send_word(8'h80, 1'b0);
		send_word("m", 1'b1);
		text_valid <= 1'b0;
		wait_for_results();

		while (live_words < 185)
			send_string();
		text_valid <= 1'b0;
		wait_for_results();

		repeat (60) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
